### hw/rtl/assert_macros.svh
// assertion macros for the rtl of the polar gaussian sampler
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, off while reset is held
`define GPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check with no reset qualifier
`define GPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hw/rtl/gps_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and functions of the polar gaussian sampler
// no dependencies
package gps_pkg;
    localparam int unsigned UNIFORM_BITS = 32;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned MAG_W        = 32;
    localparam int unsigned S_W          = 64;
    localparam int unsigned X_W          = 31;
    localparam int unsigned F_W          = 30;
    localparam int unsigned K_W          = 7;
    localparam int unsigned LZ_W         = 6;
    localparam int unsigned LZ_STAGES    = 6;
    localparam int unsigned LOG_STEPS    = 30;
    localparam int unsigned N_W          = 31;
    localparam int unsigned DIV_STEPS    = 31;
    localparam int unsigned Q_W          = 32;
    localparam int unsigned ROOT_W       = 28;
    localparam int unsigned REM_W        = 30;
    localparam int unsigned H_W          = 6;
    localparam int unsigned PROD_W       = 63;
    localparam int unsigned CAP_W        = 41;
    localparam int unsigned SAMPLE_W     = 32;
    localparam int unsigned SCALE_W      = 31;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam logic [N_W-1:0]     TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN  = 1'b0,
        CFG_SCALE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             sign_u;
        logic             sign_v;
        logic [MAG_W-1:0] mag_u;
        logic [MAG_W-1:0] mag_v;
    } t_coords;

    typedef struct packed {
        t_coords        c;
        logic [S_W-1:0] s;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // odd-centered coordinate with 32 fraction bits
    function automatic logic signed [33:0] to_coord(input logic [WORD_W-1:0] w,
                                                    input int unsigned ubits);
        logic [33:0] wm;
        logic [33:0] odd;
        wm = {2'b00, w};
        if (ubits < 32)
            wm = wm & ((34'd1 << ubits) - 34'd1);
        odd = (wm << 1) | 34'd1;
        if (ubits <= 32)
            to_coord = signed'((odd - (34'd1 << ubits)) << (32 - ubits));
        else
            to_coord = signed'((odd >> (ubits - 32)) - (34'd1 << 32));
    endfunction
endpackage

### hw/rtl/gaussian_polar_sampler.sv
`timescale 1ns / 1ps
// Gaussian sampler by the polar method: one uniform word pair in, two
// normal samples out (signed Q16.16, saturated, u sample first, v sample
// with tlast). A new pair is taken every cycle unless a kept pair is held
// back by a full queue; pairs outside the unit disk (about 21 percent) give
// no output. Every kept pair gives two output transfers, so with a steady
// stream the output port sets the pace. On its way to the output a sample
// passes two front stages, the queue write, a 6-stage normalizer, 30
// squaring stages for log2, two multiply stages, a 31-stage divider, a
// 28-stage square root, three scaling stages and the output register. A
// 4-deep queue sits between the front end and the sample pipeline.
`include "assert_macros.svh"
module gaussian_polar_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [63:0]                   i_s_tdata,   // first_word, second_word
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,   // sample
    output logic                          o_m_tlast,
    output logic                          o_m_tuser,   // clipped
    input  logic                          i_cfg_we,
    input  logic [gps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);
    logic signed [31:0]              r_mean;
    logic [gps_pkg::SCALE_W-1:0]     r_scale;
    logic                            w_push;
    logic                            w_pop;
    gps_pkg::t_job                   w_job_in;
    gps_pkg::t_job                   w_job_out;
    gps_pkg::t_q_stat                w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_scale <= gps_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (gps_pkg::t_cfg_idx'(i_cfg_idx))
                gps_pkg::CFG_MEAN:  r_mean  <= i_cfg_data;
                gps_pkg::CFG_SCALE: r_scale <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    gps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_first_word  (i_s_tdata[31:0]),
        .i_second_word (i_s_tdata[63:32]),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    gps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    gps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (w_q_stat),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .i_mean    (r_mean),
        .i_scale   (r_scale),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_sample  (o_m_tdata),
        .o_last    (o_m_tlast),
        .o_clipped (o_m_tuser)
    );

    `GPS_ASSERT(a_pair_follows, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid && o_m_tlast, "second sample missing after first transfer")
    `GPS_ASSERT(a_no_push_full, i_clk, i_rst_n, !(w_push && w_q_stat.full), "push into full queue")
    `GPS_ASSERT(a_clip_extreme, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> (o_m_tdata == 32'h7fffffff || o_m_tdata == 32'h80000000), "clipped sample not at range limit")
endmodule

### hw/rtl/gps_front.sv
`timescale 1ns / 1ps
// front end: takes uniform word pairs, maps them to coordinates, forms s
// and drops pairs outside the unit disk; uses gps_pkg
module gps_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gps_pkg::WORD_W-1:0]  i_first_word,
    input  logic [gps_pkg::WORD_W-1:0]  i_second_word,
    input  gps_pkg::t_q_stat            i_q_stat,
    output logic                        o_push,
    output gps_pkg::t_job               o_job
);
    logic signed [33:0] cu;
    logic signed [33:0] cv;
    logic [33:0]        au;
    logic [33:0]        av;
    logic [64:0]        sum;
    logic               keep;
    logic               adv;

    logic               r_v1;
    logic               r_ok1;
    gps_pkg::t_coords   r_c1;
    logic               r_v2;
    logic               r_ok2;
    gps_pkg::t_coords   r_c2;
    logic [63:0]        r_sq_u;
    logic [63:0]        r_sq_v;

    assign cu = gps_pkg::to_coord(i_first_word, gps_pkg::UNIFORM_BITS);
    assign cv = gps_pkg::to_coord(i_second_word, gps_pkg::UNIFORM_BITS);
    assign au = cu[33] ? 34'(-cu) : 34'(cu);
    assign av = cv[33] ? 34'(-cv) : 34'(cv);

    assign sum  = {1'b0, r_sq_u} + {1'b0, r_sq_v};
    assign keep = r_v2 && r_ok2 && !sum[64] && (sum[63:0] != 64'd0);
    assign adv  = !(keep && i_q_stat.full);

    assign o_ready  = adv;
    assign o_push   = keep && !i_q_stat.full;
    assign o_job.c  = r_c2;
    assign o_job.s  = sum[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok1        <= (au[33:32] == 2'b00) && (av[33:32] == 2'b00);
            r_c1.sign_u  <= cu[33];
            r_c1.sign_v  <= cv[33];
            r_c1.mag_u   <= au[31:0];
            r_c1.mag_v   <= av[31:0];
            r_ok2        <= r_ok1;
            r_c2         <= r_c1;
            r_sq_u       <= 64'(r_c1.mag_u) * 64'(r_c1.mag_u);
            r_sq_v       <= 64'(r_c1.mag_v) * 64'(r_c1.mag_v);
        end
    end
endmodule

### hw/rtl/gps_queue.sv
`timescale 1ns / 1ps
// short job queue between the front end and the sample pipeline
// uses gps_pkg
module gps_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gps_pkg::t_job     i_job,
    input  logic              i_pop,
    output gps_pkg::t_job     o_job,
    output gps_pkg::t_q_stat  o_stat
);
    localparam int unsigned DEPTH = gps_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    gps_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end
endmodule

### hw/rtl/gps_back.sv
`timescale 1ns / 1ps
// sample pipeline: normalize, log2 by squaring, divide, square root,
// scale and saturate, then hand out the two samples; uses gps_pkg
module gps_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gps_pkg::t_q_stat                   i_q_stat,
    input  gps_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic signed [gps_pkg::SAMPLE_W-1:0] i_mean,
    input  logic [gps_pkg::SCALE_W-1:0]        i_scale,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [gps_pkg::SAMPLE_W-1:0]       o_sample,
    output logic                               o_last,
    output logic                               o_clipped
);
    localparam int unsigned LZ_N  = gps_pkg::LZ_STAGES;
    localparam int unsigned LG_N  = gps_pkg::LOG_STEPS;
    localparam int unsigned DV_N  = gps_pkg::DIV_STEPS;
    localparam int unsigned SQ_N  = gps_pkg::ROOT_W;
    localparam int unsigned X_W   = gps_pkg::X_W;
    localparam int unsigned F_W   = gps_pkg::F_W;
    localparam int unsigned K_W   = gps_pkg::K_W;
    localparam int unsigned LZ_W  = gps_pkg::LZ_W;
    localparam int unsigned N_W   = gps_pkg::N_W;
    localparam int unsigned Q_W   = gps_pkg::Q_W;
    localparam int unsigned RT_W  = gps_pkg::ROOT_W;
    localparam int unsigned RM_W  = gps_pkg::REM_W;
    localparam int unsigned H_W   = gps_pkg::H_W;
    localparam int unsigned P_W   = gps_pkg::PROD_W;
    localparam int unsigned CAP_W = gps_pkg::CAP_W;
    localparam int unsigned M_W   = gps_pkg::MAG_W;

    function automatic logic [CAP_W-1:0] shift_cap(input logic [P_W-1:0] m,
                                                   input logic [H_W-1:0] h);
        logic [P_W-1:0] cap;
        logic [P_W-1:0] t;
        logic [H_W-1:0] sh;
        cap = P_W'(1) << 40;
        if (h >= H_W'(28)) begin
            sh = h - H_W'(28);
            if (m > (cap >> sh))
                t = cap;
            else
                t = m << sh;
        end else begin
            sh = H_W'(28) - h;
            t  = m >> sh;
        end
        if (t > cap)
            t = cap;
        shift_cap = t[CAP_W-1:0];
    endfunction

    function automatic logic [32:0] finish(input logic signed [31:0] mean,
                                           input logic neg,
                                           input logic [CAP_W-1:0] mag);
        logic signed [42:0] m;
        logic signed [42:0] r;
        m = signed'({2'b00, mag});
        r = 43'(mean) + (neg ? -m : m);
        if (r > 43'sd2147483647)
            finish = {1'b1, 32'h7fffffff};
        else if (r < -43'sd2147483648)
            finish = {1'b1, 32'h80000000};
        else
            finish = {1'b0, r[31:0]};
    endfunction

    logic adv;
    logic r_pair_v;
    logic r_phase;
    logic [31:0] r_smp_u;
    logic [31:0] r_smp_v;
    logic r_clip_u;
    logic r_clip_v;

    assign adv   = !r_pair_v || (i_ready && r_phase);
    assign o_pop = adv && !i_q_stat.empty;

    // normalize s, count leading zeros
    logic             r_nv  [LZ_N];
    logic [63:0]      r_ns  [LZ_N];
    logic [LZ_W-1:0]  r_nlz [LZ_N];
    gps_pkg::t_coords r_nc  [LZ_N];

    for (genvar j = 0; j < LZ_N; j++) begin : g_norm
        localparam int unsigned SH = 1 << (LZ_N - 1 - j);
        logic             v_in;
        logic [63:0]      s_in;
        logic [LZ_W-1:0]  lz_in;
        gps_pkg::t_coords c_in;
        if (j == 0) begin : g_src
            assign v_in  = !i_q_stat.empty;
            assign s_in  = i_job.s;
            assign lz_in = '0;
            assign c_in  = i_job.c;
        end else begin : g_chain
            assign v_in  = r_nv[j-1];
            assign s_in  = r_ns[j-1];
            assign lz_in = r_nlz[j-1];
            assign c_in  = r_nc[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_nv[j] <= 1'b0;
            else if (adv)
                r_nv[j] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (s_in[63 -: SH] == '0) begin
                    r_ns[j]  <= s_in << SH;
                    r_nlz[j] <= lz_in + LZ_W'(SH);
                end else begin
                    r_ns[j]  <= s_in;
                    r_nlz[j] <= lz_in;
                end
                r_nc[j] <= c_in;
            end
        end
    end

    // fraction of log2 x by repeated squaring
    logic             r_lv  [LG_N];
    logic [X_W-1:0]   r_lx  [LG_N];
    logic [X_W-1:0]   r_lx0 [LG_N];
    logic [F_W-1:0]   r_lf  [LG_N];
    logic [K_W-1:0]   r_lk  [LG_N];
    gps_pkg::t_coords r_lc  [LG_N];

    for (genvar j = 0; j < LG_N; j++) begin : g_log
        logic             v_in;
        logic [X_W-1:0]   x_in;
        logic [X_W-1:0]   x0_in;
        logic [F_W-1:0]   f_in;
        logic [K_W-1:0]   k_in;
        gps_pkg::t_coords c_in;
        logic [61:0]      sq;
        if (j == 0) begin : g_src
            assign v_in  = r_nv[LZ_N-1];
            assign x_in  = r_ns[LZ_N-1][63:33];
            assign x0_in = r_ns[LZ_N-1][63:33];
            assign f_in  = '0;
            assign k_in  = K_W'(r_nlz[LZ_N-1]) + 1'b1;
            assign c_in  = r_nc[LZ_N-1];
        end else begin : g_chain
            assign v_in  = r_lv[j-1];
            assign x_in  = r_lx[j-1];
            assign x0_in = r_lx0[j-1];
            assign f_in  = r_lf[j-1];
            assign k_in  = r_lk[j-1];
            assign c_in  = r_lc[j-1];
        end
        assign sq = 62'(x_in) * 62'(x_in);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_lv[j] <= 1'b0;
            else if (adv)
                r_lv[j] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (sq[61]) begin
                    r_lx[j] <= sq[61:31];
                    r_lf[j] <= {f_in[F_W-2:0], 1'b1};
                end else begin
                    r_lx[j] <= sq[60:30];
                    r_lf[j] <= {f_in[F_W-2:0], 1'b0};
                end
                r_lx0[j] <= x0_in;
                r_lk[j]  <= k_in;
                r_lc[j]  <= c_in;
            end
        end
    end

    // -2 ln s in Q24
    logic             r_m1_v;
    logic [N_W-1:0]   r_m1_l;
    logic [X_W-1:0]   r_m1_x0;
    logic [K_W-1:0]   r_m1_k;
    gps_pkg::t_coords r_m1_c;
    logic             r_m2_v;
    logic [N_W-1:0]   r_m2_n;
    logic [X_W-1:0]   r_m2_x0;
    logic [K_W-1:0]   r_m2_k;
    gps_pkg::t_coords r_m2_c;
    logic [36:0]      l_full;
    logic [61:0]      n_full;

    assign l_full = {r_lk[LG_N-1], 30'd0} - 37'(r_lf[LG_N-1]);
    assign n_full = 62'(r_m1_l) * 62'(gps_pkg::TWO_LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (adv) begin
            r_m1_v <= r_lv[LG_N-1];
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_l  <= l_full[36:6];
            r_m1_x0 <= r_lx0[LG_N-1];
            r_m1_k  <= r_lk[LG_N-1];
            r_m1_c  <= r_lc[LG_N-1];
            r_m2_n  <= n_full[60:30];
            r_m2_x0 <= r_m1_x0;
            r_m2_k  <= r_m1_k;
            r_m2_c  <= r_m1_c;
        end
    end

    // restoring divide, one quotient bit per stage
    logic             r_dv   [DV_N];
    logic [X_W-1:0]   r_drem [DV_N];
    logic [N_W-1:0]   r_dq   [DV_N];
    logic [X_W-1:0]   r_dden [DV_N];
    logic [K_W-1:0]   r_dk   [DV_N];
    gps_pkg::t_coords r_dc   [DV_N];

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        logic             v_in;
        logic [X_W-1:0]   rem_in;
        logic             bit_in;
        logic [N_W-1:0]   q_in;
        logic [X_W-1:0]   den_in;
        logic [K_W-1:0]   k_in;
        gps_pkg::t_coords c_in;
        logic [X_W:0]     t;
        if (j == 0) begin : g_src
            assign v_in   = r_m2_v;
            assign rem_in = {1'b0, r_m2_n[N_W-1:1]};
            assign bit_in = r_m2_n[0];
            assign q_in   = '0;
            assign den_in = r_m2_x0;
            assign k_in   = r_m2_k;
            assign c_in   = r_m2_c;
        end else begin : g_chain
            assign v_in   = r_dv[j-1];
            assign rem_in = r_drem[j-1];
            assign bit_in = 1'b0;
            assign q_in   = r_dq[j-1];
            assign den_in = r_dden[j-1];
            assign k_in   = r_dk[j-1];
            assign c_in   = r_dc[j-1];
        end
        assign t = {rem_in, bit_in};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_dv[j] <= 1'b0;
            else if (adv)
                r_dv[j] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (t >= {1'b0, den_in}) begin
                    r_drem[j] <= X_W'(t - {1'b0, den_in});
                    r_dq[j]   <= {q_in[N_W-2:0], 1'b1};
                end else begin
                    r_drem[j] <= t[X_W-1:0];
                    r_dq[j]   <= {q_in[N_W-2:0], 1'b0};
                end
                r_dden[j] <= den_in;
                r_dk[j]   <= k_in;
                r_dc[j]   <= c_in;
            end
        end
    end

    // odd exponent folds into the radicand
    logic [Q_W-1:0] q_even;
    logic [H_W-1:0] h_div;

    assign q_even = r_dk[DV_N-1][0] ? {r_dq[DV_N-1], 1'b0} : {1'b0, r_dq[DV_N-1]};
    assign h_div  = r_dk[DV_N-1][K_W-1:1];

    // digit by digit square root of q << 24
    logic             r_sv    [SQ_N];
    logic [Q_W-1:0]   r_sq    [SQ_N];
    logic [RM_W-1:0]  r_srem  [SQ_N];
    logic [RT_W-1:0]  r_sroot [SQ_N];
    logic [H_W-1:0]   r_sh    [SQ_N];
    gps_pkg::t_coords r_sc    [SQ_N];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int unsigned P = SQ_N - 1 - j;
        logic             v_in;
        logic [Q_W-1:0]   q_in;
        logic [RM_W-1:0]  rem_in;
        logic [RT_W-1:0]  root_in;
        logic [H_W-1:0]   h_in;
        gps_pkg::t_coords c_in;
        logic [Q_W+23:0]  rad;
        logic [RM_W+1:0]  t;
        logic [RM_W+1:0]  trial;
        if (j == 0) begin : g_src
            assign v_in    = r_dv[DV_N-1];
            assign q_in    = q_even;
            assign rem_in  = '0;
            assign root_in = '0;
            assign h_in    = h_div;
            assign c_in    = r_dc[DV_N-1];
        end else begin : g_chain
            assign v_in    = r_sv[j-1];
            assign q_in    = r_sq[j-1];
            assign rem_in  = r_srem[j-1];
            assign root_in = r_sroot[j-1];
            assign h_in    = r_sh[j-1];
            assign c_in    = r_sc[j-1];
        end
        assign rad   = {q_in, 24'd0};
        assign t     = {rem_in, rad[2*P+1 -: 2]};
        assign trial = {(RM_W + 2 - RT_W - 2)'(0), root_in, 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_sv[j] <= 1'b0;
            else if (adv)
                r_sv[j] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (t >= trial) begin
                    r_srem[j]  <= RM_W'(t - trial);
                    r_sroot[j] <= {root_in[RT_W-2:0], 1'b1};
                end else begin
                    r_srem[j]  <= t[RM_W-1:0];
                    r_sroot[j] <= {root_in[RT_W-2:0], 1'b0};
                end
                r_sq[j] <= q_in;
                r_sh[j] <= h_in;
                r_sc[j] <= c_in;
            end
        end
    end

    // scale both coordinates
    logic             r_p1_v;
    logic [M_W-1:0]   r_p1_u;
    logic [M_W-1:0]   r_p1_w;
    logic [H_W-1:0]   r_p1_h;
    logic             r_p1_su;
    logic             r_p1_sw;
    logic             r_p2_v;
    logic [P_W-1:0]   r_p2_u;
    logic [P_W-1:0]   r_p2_w;
    logic [H_W-1:0]   r_p2_h;
    logic             r_p2_su;
    logic             r_p2_sw;
    logic             r_p3_v;
    logic [CAP_W-1:0] r_p3_u;
    logic [CAP_W-1:0] r_p3_w;
    logic             r_p3_su;
    logic             r_p3_sw;
    logic [59:0]      pu;
    logic [59:0]      pw;
    logic [32:0]      fin_u;
    logic [32:0]      fin_w;
    gps_pkg::t_coords sc_last;

    assign sc_last = r_sc[SQ_N-1];
    assign pu      = 60'(sc_last.mag_u) * 60'(r_sroot[SQ_N-1]);
    assign pw      = 60'(sc_last.mag_v) * 60'(r_sroot[SQ_N-1]);
    assign fin_u   = finish(i_mean, r_p3_su, r_p3_u);
    assign fin_w   = finish(i_mean, r_p3_sw, r_p3_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else if (adv) begin
            r_p1_v <= r_sv[SQ_N-1];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_u  <= pu[59:28];
            r_p1_w  <= pw[59:28];
            r_p1_h  <= r_sh[SQ_N-1];
            r_p1_su <= sc_last.sign_u;
            r_p1_sw <= sc_last.sign_v;
            r_p2_u  <= P_W'(r_p1_u) * P_W'(i_scale);
            r_p2_w  <= P_W'(r_p1_w) * P_W'(i_scale);
            r_p2_h  <= r_p1_h;
            r_p2_su <= r_p1_su;
            r_p2_sw <= r_p1_sw;
            r_p3_u  <= shift_cap(r_p2_u, r_p2_h);
            r_p3_w  <= shift_cap(r_p2_w, r_p2_h);
            r_p3_su <= r_p2_su;
            r_p3_sw <= r_p2_sw;
        end
    end

    // output pair, u sample first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_v <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            if (adv)
                r_pair_v <= r_p3_v;
            if (r_pair_v && i_ready)
                r_phase <= !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_smp_u  <= fin_u[31:0];
            r_clip_u <= fin_u[32];
            r_smp_v  <= fin_w[31:0];
            r_clip_v <= fin_w[32];
        end
    end

    assign o_valid   = r_pair_v;
    assign o_last    = r_phase;
    assign o_sample  = r_phase ? r_smp_v : r_smp_u;
    assign o_clipped = r_phase ? r_clip_v : r_clip_u;
endmodule
